@@ design/sha256_stream_hasher_assert.svh @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/shs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg
// Word type, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned CHAIN_WORDS = 8;
  localparam int unsigned COUNT_W     = 61;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [WORD_W-1:0] word_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t major(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t init_h(logic [2:0] i);
    word_t v;
    case (i)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      3'd7:    v = 32'h5be0cd19;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(logic [5:0] t);
    word_t v;
    case (t)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, one byte per input word, digest out as
// eight 32-bit words.
// ----------------------------------------------------------------------------
// Each input word carries at most one message byte and may mark the end of
// the message. Bytes are taken one per cycle while the hasher is idle; the
// 64th byte of a block starts the compression, which holds in_stall high
// through 64 rounds on the single round datapath and the chaining update.
// The end mark adds a padding step and one more compression; when the last
// block holds 56 or more bytes the length needs a block of its own, which
// costs a length step and a second compression. Then the output register
// is loaded and the digest words go out one per cycle while out_stall is
// low, H0 first, with out_last_word set on the eighth. Output stall
// stretches that phase; no new input is taken until the last digest word
// has gone out, after which the chaining words, fill and length reset for
// the next message. The bit length in the padding wraps modulo 2^64.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_assert.svh"

module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  // digest output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // S_PAD: 0x80 plus zeros, length too if it fits
  // S_LEN: extra block of zeros plus length
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_COMP,
    S_ADD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // message block, doubles as the 16-word schedule window during rounds
  shs_pkg::word_t w_r   [shs_pkg::BLOCK_WORDS];
  shs_pkg::word_t w_nxt [shs_pkg::BLOCK_WORDS];
  // chaining words and working variables a..h
  shs_pkg::word_t h_r   [shs_pkg::CHAIN_WORDS];
  shs_pkg::word_t h_nxt [shs_pkg::CHAIN_WORDS];
  shs_pkg::word_t r_r   [shs_pkg::CHAIN_WORDS];
  shs_pkg::word_t r_nxt [shs_pkg::CHAIN_WORDS];

  logic [5:0]                  fill_r, fill_nxt;
  logic [shs_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [5:0]                  rnd_r, rnd_nxt;

  // what follows the current compression
  logic pad_pend_r, pad_pend_nxt;
  logic len_pend_r, len_pend_nxt;
  logic fin_pend_r, fin_pend_nxt;

  logic           out_valid_r, out_valid_nxt;
  shs_pkg::word_t out_digest_r, out_digest_nxt;
  logic [2:0]     out_index_r, out_index_nxt;
  logic           out_last_r, out_last_nxt;

  logic           in_fire;
  logic           out_fire;
  logic [63:0]    bit_len;
  shs_pkg::word_t byte_word;
  shs_pkg::word_t pad_word;
  shs_pkg::word_t t1;
  shs_pkg::word_t t2;
  shs_pkg::word_t w_new;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_digest_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

  assign in_fire  = in_valid && (state_r == S_IDLE);
  assign out_fire = out_valid_r && !out_stall;

  // big-endian byte lanes: position 0 of a word lands in bits 31:24
  assign byte_word = shs_pkg::word_t'({24'b0, in_msg_byte}) << {~fill_r[1:0], 3'b000};
  assign pad_word  = shs_pkg::word_t'({24'b0, shs_pkg::PAD_BYTE}) << {~fill_r[1:0], 3'b000};
  assign bit_len   = {count_r, 3'b000};

  // round datapath
  assign t1 = r_r[7] + shs_pkg::bsig1(r_r[4]) + shs_pkg::choose(r_r[4], r_r[5], r_r[6])
            + shs_pkg::round_k(rnd_r) + w_r[0];
  assign t2 = shs_pkg::bsig0(r_r[0]) + shs_pkg::major(r_r[0], r_r[1], r_r[2]);
  // schedule: window slides one word per round, W[t] is always w_r[0]
  assign w_new = shs_pkg::ssig1(w_r[14]) + w_r[9] + shs_pkg::ssig0(w_r[1]) + w_r[0];

  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    r_nxt          = r_r;
    fill_nxt       = fill_r;
    count_nxt      = count_r;
    rnd_nxt        = rnd_r;
    pad_pend_nxt   = pad_pend_r;
    len_pend_nxt   = len_pend_r;
    fin_pend_nxt   = fin_pend_r;
    out_valid_nxt  = out_valid_r;
    out_digest_nxt = out_digest_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_byte_present) begin
            // first byte of a word clears its lower lanes
            if (fill_r[1:0] == 2'd0) begin
              w_nxt[fill_r[5:2]] = byte_word;
            end else begin
              w_nxt[fill_r[5:2]] = w_r[fill_r[5:2]] | byte_word;
            end
            fill_nxt  = fill_r + 6'd1;
            count_nxt = count_r + shs_pkg::COUNT_W'(1);
            if (fill_r == 6'd63) begin
              state_nxt    = S_COMP;
              pad_pend_nxt = in_end_of_message;
            end else if (in_end_of_message) begin
              state_nxt = S_PAD;
            end
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        for (int i = 0; i < shs_pkg::BLOCK_WORDS; i++) begin
          if (4'(i) > fill_r[5:2]) begin
            w_nxt[i] = '0;
          end
        end
        if (fill_r[1:0] == 2'd0) begin
          w_nxt[fill_r[5:2]] = pad_word;
        end else begin
          w_nxt[fill_r[5:2]] = w_r[fill_r[5:2]] | pad_word;
        end
        if (fill_r[5:3] == 3'b111) begin
          // no room for the length: it goes in an extra block
          len_pend_nxt = 1'b1;
        end else begin
          w_nxt[14]    = bit_len[63:32];
          w_nxt[15]    = bit_len[31:0];
          fin_pend_nxt = 1'b1;
        end
        state_nxt = S_COMP;
      end

      S_LEN: begin
        for (int i = 0; i < shs_pkg::BLOCK_WORDS; i++) begin
          w_nxt[i] = '0;
        end
        w_nxt[14]    = bit_len[63:32];
        w_nxt[15]    = bit_len[31:0];
        len_pend_nxt = 1'b0;
        fin_pend_nxt = 1'b1;
        state_nxt    = S_COMP;
      end

      S_COMP: begin
        r_nxt[7] = r_r[6];
        r_nxt[6] = r_r[5];
        r_nxt[5] = r_r[4];
        r_nxt[4] = r_r[3] + t1;
        r_nxt[3] = r_r[2];
        r_nxt[2] = r_r[1];
        r_nxt[1] = r_r[0];
        r_nxt[0] = t1 + t2;
        for (int i = 0; i < shs_pkg::BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[shs_pkg::BLOCK_WORDS-1] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        for (int i = 0; i < shs_pkg::CHAIN_WORDS; i++) begin
          h_nxt[i] = h_r[i] + r_r[i];
        end
        if (pad_pend_r) begin
          pad_pend_nxt = 1'b0;
          state_nxt    = S_PAD;
        end else if (len_pend_r) begin
          state_nxt = S_LEN;
        end else if (fin_pend_r) begin
          fin_pend_nxt  = 1'b0;
          out_index_nxt = '0;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt  = 1'b1;
          out_digest_nxt = h_r[out_index_r];
          out_last_nxt   = (out_index_r == 3'd7);
        end else if (out_fire) begin
          if (out_last_r) begin
            // digest delivered: fresh state for the next message
            out_valid_nxt = 1'b0;
            fill_nxt      = '0;
            count_nxt     = '0;
            for (int i = 0; i < shs_pkg::CHAIN_WORDS; i++) begin
              h_nxt[i] = shs_pkg::init_h(3'(i));
            end
            state_nxt = S_IDLE;
          end else begin
            out_index_nxt  = out_index_r + 3'd1;
            out_digest_nxt = h_r[out_index_r + 3'd1];
            out_last_nxt   = (out_index_r + 3'd1 == 3'd7);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // working variables start from the chaining words
    if ((state_nxt == S_COMP) && (state_r != S_COMP)) begin
      r_nxt = h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      rnd_r       <= '0;
      pad_pend_r  <= 1'b0;
      len_pend_r  <= 1'b0;
      fin_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_index_r <= '0;
      out_last_r  <= 1'b0;
      for (int i = 0; i < shs_pkg::CHAIN_WORDS; i++) begin
        h_r[i] <= shs_pkg::init_h(3'(i));
      end
    end else begin
      state_r      <= state_nxt;
      w_r          <= w_nxt;
      h_r          <= h_nxt;
      r_r          <= r_nxt;
      fill_r       <= fill_nxt;
      count_r      <= count_nxt;
      rnd_r        <= rnd_nxt;
      pad_pend_r   <= pad_pend_nxt;
      len_pend_r   <= len_pend_nxt;
      fin_pend_r   <= fin_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      out_digest_r <= out_digest_nxt;
      out_index_r  <= out_index_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // ---- checks ----
  `SHS_ASSERT_SAME(a_out_only_in_out, out_valid_r, state_r == S_OUT, "digest valid outside output phase")
  `SHS_ASSERT_NEXT(a_round_end, (state_r == S_COMP) && (rnd_r == 6'd63), (state_r == S_ADD) && (rnd_r == 6'd0), "round count did not close the block")
  `SHS_ASSERT_NEXT(a_index_step, out_fire && !out_last_r, out_index_r == $past(out_index_r) + 3'd1, "digest word index skipped")
  `SHS_ASSERT_NEXT(a_reinit, out_fire && out_last_r, (state_r == S_IDLE) && (fill_r == 6'd0) && (count_r == '0) && (h_r[0] == shs_pkg::init_h(3'd0)), "hasher not reinitialized after digest")
  `SHS_ASSERT_NEXT(a_end_starts_pad, in_fire && in_end_of_message, (state_r == S_PAD) || (state_r == S_COMP), "end mark did not start padding")

endmodule

@@ tb/sha256_stream_hasher_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_checker
// Watches both channels of the hasher, computes the expected digest of
// each message from the accepted input words and compares every digest
// word with it.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          mismatch_count,
  output int          words_due
);

  typedef shs_pkg::word_t word_t;

  typedef struct packed {
    word_t      digest;
    logic [2:0] index;
    logic       last;
  } digest_word_t;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [64*32-1:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  word_t        hash_state [8];
  word_t        block_buf  [16];
  logic [5:0]   block_count;
  logic [60:0]  msg_len;
  digest_word_t digest_due [$];
  digest_word_t want;

  function automatic word_t ror32(word_t v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  task automatic clear_hash();
    int i;
    for (i = 0; i < 8; i++) hash_state[i] = H_INIT[(7 - i) * 32 +: 32];
    for (i = 0; i < 16; i++) block_buf[i] = '0;
    block_count = '0;
    msg_len     = '0;
  endtask

  task automatic run_rounds();
    word_t w [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    int    t;
    for (t = 0; t < 16; t++) w[t] = block_buf[t];
    for (t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (t = 0; t < 8; t++) v[t] = hash_state[t];
    for (t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[(63 - t) * 32 +: 32] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) hash_state[t] = hash_state[t] + v[t];
  endtask

  // big-endian byte lanes; lane 0 starts a fresh word
  task automatic place_byte(logic [5:0] pos, logic [7:0] b);
    if (pos[1:0] == 2'd0) begin
      block_buf[pos[5:2]] = {b, 24'h0};
    end else begin
      block_buf[pos[5:2]] = block_buf[pos[5:2]] | (word_t'(b) << (24 - 8 * pos[1:0]));
    end
  endtask

  task automatic absorb_word(logic [7:0] b, logic present, logic eom);
    logic [63:0]  bit_len;
    digest_word_t due_word;
    int           i;
    if (present) begin
      place_byte(block_count, b);
      block_count = block_count + 6'd1;
      msg_len     = msg_len + 61'd1;
      if (block_count == 6'd0) run_rounds();
    end
    if (eom) begin
      place_byte(block_count, PAD_MARK);
      for (i = int'(block_count[5:2]) + 1; i < 16; i++) block_buf[i] = '0;
      // no room for the length: flush this block, length goes in a fresh one
      if (block_count >= 6'd56) begin
        run_rounds();
        for (i = 0; i < 16; i++) block_buf[i] = '0;
      end
      bit_len = {msg_len, 3'b000};
      block_buf[14] = bit_len[63:32];
      block_buf[15] = bit_len[31:0];
      run_rounds();
      for (i = 0; i < 8; i++) begin
        due_word   = '{digest: hash_state[i], index: 3'(i), last: (i == 7)};
        digest_due = {digest_due, due_word};
      end
      clear_hash();
    end
  endtask

  task automatic report_mismatch(string what, word_t expected, word_t got);
    $display("%0t: digest mismatch, %s: expected %h, got %h", $realtime, what, expected, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_hash();
      digest_due.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_word(in_msg_byte, in_byte_present, in_end_of_message);
      end
      if (out_valid && !out_stall) begin
        if (digest_due.size() == 0) begin
          report_mismatch("unexpected word", '0, out_digest_word);
        end else begin
          want = digest_due.pop_front();
          if (out_digest_word !== want.digest) begin
            report_mismatch("digest_word", want.digest, out_digest_word);
          end
          if (out_word_index !== want.index) begin
            report_mismatch("word_index", word_t'(want.index), word_t'(out_word_index));
          end
          if (out_last_word !== want.last) begin
            report_mismatch("last_word", word_t'(want.last), word_t'(out_last_word));
          end
        end
      end
    end
    words_due = digest_due.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the SHA-256 stream hasher and leaves prediction
// and comparison of the digest words to the checker beside it.
// ----------------------------------------------------------------------------
module testbench;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet spell is the long output hold-off plus two
  // compressions and a few stall bursts.
  localparam int HANG_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 400;
  // after the last digest word: time for any tail activity to settle
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEM_TARGET  = 500;
  localparam int QUIET_AFTER  = 430;
  localparam int HOLD_AFTER   = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_msg_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int mismatch_count;
  int words_due;

  // items_sent and quiet are shared between the stimulus and the receiver
  int items_sent = 0;     // words carrying a byte or an end mark
  bit quiet      = 1'b0;  // tail of the run: no idling on either side
  bit send_gaps  = 1'b1;

  always #5 clk = ~clk;

  sha256_stream_hasher DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_msg_byte       (in_msg_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  sha256_stream_hasher_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_msg_byte       (in_msg_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .mismatch_count    (mismatch_count),
    .words_due         (words_due)
  );

  // Offer one input word and hold it until accepted. A random idle burst
  // may come first; valid drops only in the step after an acceptance, so it
  // never gets two updates in one step.
  task automatic drive_word(logic [7:0] b, logic present, logic eom);
    if (!quiet && send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_msg_byte       <= b;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (present || eom) items_sent++;
  endtask

  // One message of random bytes. The end mark either rides on the last
  // byte or comes as a word of its own; with noise on, empty words (no byte,
  // no end) are sprinkled in and must be ignored.
  task automatic send_message(int len, bit end_on_byte, bit noisy);
    int k;
    for (k = 0; k < len; k++) begin
      if (noisy && $urandom_range(0, 9) == 0) drive_word(8'($urandom), 1'b0, 1'b0);
      drive_word(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
    end
    if (!end_on_byte || len == 0) drive_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stimulus and verdict.
  initial begin
    int msg_len;
    int pick;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_msg_byte       <= '0;
    in_byte_present   <= 1'b0;
    in_end_of_message <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, byte and end mark in one word at both byte
    // extremes, an ignored empty word, "abc", and a bare end mark after data.
    drive_word(8'h00, 1'b0, 1'b1);
    drive_word(8'h00, 1'b1, 1'b1);
    drive_word(8'hff, 1'b1, 1'b1);
    drive_word(8'hff, 1'b0, 1'b0);
    drive_word(8'h61, 1'b1, 1'b0);
    drive_word(8'h62, 1'b1, 1'b0);
    drive_word(8'h63, 1'b1, 1'b1);
    drive_word(8'h5a, 1'b1, 1'b0);
    drive_word(8'ha5, 1'b0, 1'b0);
    drive_word(8'h00, 1'b0, 1'b1);

    // Random messages. Lengths cluster on short ones and on the padding
    // boundaries (55/56 bytes, full blocks, the 119..128 region) so that
    // both the one- and two-block tails get hit often.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      msg_len = $urandom_range(0, 8);
      else if (pick < 8) msg_len = $urandom_range(50, 72);
      else               msg_len = $urandom_range(100, 140);
      send_gaps = ($urandom_range(0, 2) != 0);
      send_message(msg_len, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
    end
    in_valid <= 1'b0;

    // drain: every predicted word back, then let any tail activity settle
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Receiver: random stall bursts in phases, plus one long hold-off while
  // digest words are waiting so the hasher backs up and stalls its input.
  initial begin
    int  cycle_no;
    bit  held;
    bit  stalls_on;
    cycle_no  = 0;
    held      = 1'b0;
    stalls_on = 1'b1;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no % 64 == 0) stalls_on = ($urandom_range(0, 2) != 0);
      if (!held && items_sent >= HOLD_AFTER && out_valid) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hang detector: too long without a word moving on either channel.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < HANG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("%0t: no word moved for %0d cycles", $realtime, HANG_LIMIT);
    $display("testbench failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/shs_pkg.sv
design/sha256_stream_hasher.sv
tb/sha256_stream_hasher_checker.sv
tb/testbench.sv
